// ----- design/tpi_pkg.sv -----
// Shared types and fixed widths for the triangle plane interpolation pipeline.
package tpi_pkg;

    localparam int unsigned COORD_W = 32;                  // angle and value fields
    localparam int unsigned DIFF_W  = COORD_W + 1;         // vertex and query offsets
    localparam int unsigned PROD_W  = 2 * DIFF_W;          // offset products
    localparam int unsigned COEF_W  = PROD_W;              // plane coefficients, |c| < 2^65
    localparam int unsigned SPLIT_W = 33;                  // low slice of a coefficient
    localparam int unsigned HI_W    = COEF_W - SPLIT_W;    // high slice of a coefficient
    localparam int unsigned PH_W    = HI_W + DIFF_W;       // high partial product
    localparam int unsigned PL_W    = SPLIT_W + 1 + DIFF_W; // low partial product
    localparam int unsigned SH_W    = PH_W + 1;            // sum of high partials
    localparam int unsigned SL_W    = PL_W + 1;            // sum of low partials
    localparam int unsigned NUM_W   = 99;                  // numerator, |num| < 2^98
    localparam int unsigned NMAG_W  = NUM_W - 1;           // numerator magnitude
    localparam int unsigned DMAG_W  = COEF_W - 1;          // divisor magnitude
    localparam int unsigned QUOT_W  = NMAG_W - DMAG_W;     // quotient bits kept
    localparam int unsigned QMAG_W  = QUOT_W + 1;          // quotient magnitude, clamped
    localparam int unsigned QSGN_W  = QMAG_W + 1;          // signed quotient
    localparam int unsigned RES_W   = QSGN_W + 1;          // value minus quotient

    localparam logic signed [COORD_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] VALUE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_lon;
        logic signed [COORD_W-1:0] first_lat;
        logic signed [COORD_W-1:0] first_value;
        logic signed [COORD_W-1:0] second_lon;
        logic signed [COORD_W-1:0] second_lat;
        logic signed [COORD_W-1:0] second_value;
        logic signed [COORD_W-1:0] third_lon;
        logic signed [COORD_W-1:0] third_lat;
        logic signed [COORD_W-1:0] third_value;
        logic signed [COORD_W-1:0] query_lon;
        logic signed [COORD_W-1:0] query_lat;
    } query_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] interpolated_value;
        logic                      degenerate;
    } result_t;

    // Side information that rides along with each division
    typedef struct packed {
        logic signed [COORD_W-1:0] first_value;
        logic                      neg;
        logic                      ovf;
        logic                      degen;
    } div_tag_t;

endpackage

// ----- design/tpi_div.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
module tpi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          src_valid,
    input  logic [tpi_pkg::DMAG_W-1:0]    src_rem,
    input  logic [tpi_pkg::QUOT_W-1:0]    src_low,
    input  logic [tpi_pkg::DMAG_W-1:0]    src_dvs,
    input  tpi_pkg::div_tag_t             src_tag,
    output logic                          done_valid,
    output logic [tpi_pkg::QUOT_W-1:0]    done_quot,
    output logic [tpi_pkg::DMAG_W-1:0]    done_rem,
    output logic [tpi_pkg::DMAG_W-1:0]    done_dvs,
    output tpi_pkg::div_tag_t             done_tag
);

    localparam int unsigned STAGES = tpi_pkg::QUOT_W;

    logic                          valid_reg [STAGES];
    logic [tpi_pkg::DMAG_W-1:0]    rem_reg   [STAGES];
    logic [tpi_pkg::QUOT_W-1:0]    low_reg   [STAGES];
    logic [tpi_pkg::QUOT_W-1:0]    quot_reg  [STAGES];
    logic [tpi_pkg::DMAG_W-1:0]    dvs_reg   [STAGES];
    tpi_pkg::div_tag_t             tag_reg   [STAGES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic                          valid_prev;
        logic [tpi_pkg::DMAG_W-1:0]    rem_prev;
        logic [tpi_pkg::QUOT_W-1:0]    low_prev;
        logic [tpi_pkg::QUOT_W-1:0]    quot_prev;
        logic [tpi_pkg::DMAG_W-1:0]    dvs_prev;
        tpi_pkg::div_tag_t             tag_prev;
        logic [tpi_pkg::DMAG_W:0]      trial;
        logic [tpi_pkg::DMAG_W:0]      diff;
        logic                          take;
        logic [tpi_pkg::DMAG_W-1:0]    rem_next;
        logic [tpi_pkg::QUOT_W-1:0]    low_next;
        logic [tpi_pkg::QUOT_W-1:0]    quot_next;

        if (k == 0)
        begin : g_first
            assign valid_prev = src_valid;
            assign rem_prev   = src_rem;
            assign low_prev   = src_low;
            assign quot_prev  = '0;
            assign dvs_prev   = src_dvs;
            assign tag_prev   = src_tag;
        end
        else
        begin : g_chain
            assign valid_prev = valid_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign low_prev   = low_reg[k-1];
            assign quot_prev  = quot_reg[k-1];
            assign dvs_prev   = dvs_reg[k-1];
            assign tag_prev   = tag_reg[k-1];
        end

        // Bring down the next dividend bit and try the subtraction
        assign trial     = {rem_prev, low_prev[tpi_pkg::QUOT_W-1]};
        assign diff      = trial - {1'b0, dvs_prev};
        assign take      = (trial >= {1'b0, dvs_prev});
        assign rem_next  = take ? diff[tpi_pkg::DMAG_W-1:0] : trial[tpi_pkg::DMAG_W-1:0];
        assign low_next  = {low_prev[tpi_pkg::QUOT_W-2:0], 1'b0};
        assign quot_next = {quot_prev[tpi_pkg::QUOT_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_next;
                quot_reg[k] <= quot_next;
                dvs_reg[k]  <= dvs_prev;
                tag_reg[k]  <= tag_prev;
            end
        end
    end

    assign done_valid = valid_reg[STAGES-1];
    assign done_quot  = quot_reg[STAGES-1];
    assign done_rem   = rem_reg[STAGES-1];
    assign done_dvs   = dvs_reg[STAGES-1];
    assign done_tag   = tag_reg[STAGES-1];

endmodule

// ----- design/triangle_plane_interpolation.sv -----
// Top level of the triangle plane interpolation pipeline.
//
//  channel  | handshake                   | payload             | direction
//  ---------+-----------------------------+---------------------+----------
//  query    | query_valid / query_ready   | tpi_pkg::query_t    | in
//  result   | result_valid / result_ready | tpi_pkg::result_t   | out
//
// One transaction enters per cycle unless a result waits at the output;
// each result passes eight arithmetic stages, 33 divider stages (one
// quotient bit each) and the output register. The divider chain dominates.
// Reset clears only the valid bits; data registers are not reset.
// A result held at the output stalls the whole pipeline in place; nothing
// is dropped or repeated, and bubbles move freely while the output is free.
module triangle_plane_interpolation (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_valid,
    output logic              query_ready,
    input  tpi_pkg::query_t   query,
    output logic              result_valid,
    input  logic              result_ready,
    output tpi_pkg::result_t  result
);

    localparam int unsigned DW = tpi_pkg::DIFF_W;
    localparam int unsigned PW = tpi_pkg::PROD_W;
    localparam int unsigned CW = tpi_pkg::COEF_W;
    localparam int unsigned SW = tpi_pkg::SPLIT_W;
    localparam int unsigned VW = tpi_pkg::COORD_W;

    logic en;

    // Stage valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic result_valid_reg;

    // Stage 1: offsets from the first vertex
    logic signed [DW-1:0] dlon2_reg, dlat2_reg, dval2_reg;
    logic signed [DW-1:0] dlon3_reg, dlat3_reg, dval3_reg;
    logic signed [DW-1:0] dlonq1_reg, dlatq1_reg;
    logic signed [VW-1:0] val1_s1_reg;

    // Stage 2: cross product terms
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [DW-1:0] dlonq2_reg, dlatq2_reg;
    logic signed [VW-1:0] val1_s2_reg;

    // Stage 3: plane coefficients
    logic signed [CW-1:0] c0_reg, c1_reg, c2_reg;
    logic signed [DW-1:0] dlonq3_reg, dlatq3_reg;
    logic signed [VW-1:0] val1_s3_reg;

    // Stage 4: split partial products, divisor magnitude
    logic signed [tpi_pkg::PH_W-1:0]  h0_reg, h1_reg;
    logic signed [tpi_pkg::PL_W-1:0]  l0_reg, l1_reg;
    logic [tpi_pkg::DMAG_W-1:0]       dmag_s4_reg;
    logic                             dneg_s4_reg, degen_s4_reg;
    logic signed [VW-1:0]             val1_s4_reg;

    // Stage 5: partial sums
    logic signed [tpi_pkg::SH_W-1:0]  sh_reg;
    logic signed [tpi_pkg::SL_W-1:0]  sl_reg;
    logic [tpi_pkg::DMAG_W-1:0]       dmag_s5_reg;
    logic                             dneg_s5_reg, degen_s5_reg;
    logic signed [VW-1:0]             val1_s5_reg;

    // Stage 6: numerator
    logic signed [tpi_pkg::NUM_W-1:0] num_reg;
    logic [tpi_pkg::DMAG_W-1:0]       dmag_s6_reg;
    logic                             dneg_s6_reg, degen_s6_reg;
    logic signed [VW-1:0]             val1_s6_reg;

    // Stage 7: numerator magnitude and quotient sign
    logic [tpi_pkg::NMAG_W-1:0]       nmag_reg;
    logic [tpi_pkg::DMAG_W-1:0]       dmag_s7_reg;
    logic                             qneg_s7_reg, degen_s7_reg;
    logic signed [VW-1:0]             val1_s7_reg;

    // Stage 8: divider operands and overflow flag
    logic [tpi_pkg::DMAG_W-1:0]       drem_reg;
    logic [tpi_pkg::QUOT_W-1:0]       dlow_reg;
    logic [tpi_pkg::DMAG_W-1:0]       ddvs_reg;
    tpi_pkg::div_tag_t                dtag_reg;

    // Divider outputs
    logic                             div_valid;
    logic [tpi_pkg::QUOT_W-1:0]       div_quot;
    logic [tpi_pkg::DMAG_W-1:0]       div_rem;
    logic [tpi_pkg::DMAG_W-1:0]       div_dvs;
    tpi_pkg::div_tag_t                div_tag;

    tpi_pkg::result_t                 result_reg;

    // Combinational next values
    logic signed [PW-1:0]             c_full0, c_full1;
    logic signed [tpi_pkg::HI_W-1:0]  c0_hi, c1_hi;
    logic signed [SW:0]               c0_lo, c1_lo;
    logic [CW-1:0]                    c2_abs;
    logic [tpi_pkg::NUM_W-1:0]        num_abs;
    logic [tpi_pkg::QMAG_W-1:0]       qmag;
    logic signed [tpi_pkg::QSGN_W-1:0] qsgn;
    logic signed [tpi_pkg::RES_W-1:0] res_wide;
    logic [tpi_pkg::RES_W-VW:0]       res_top;
    tpi_pkg::result_t                 result_next;

    // Advance everything unless a result is waiting at the output
    assign en          = !result_valid_reg || result_ready;
    assign query_ready = en;

    always_comb
    begin
        c_full0 = c0_reg;
        c_full1 = c1_reg;
        c0_hi   = c_full0[CW-1:SW];
        c1_hi   = c_full1[CW-1:SW];
        c0_lo   = {1'b0, c_full0[SW-1:0]};
        c1_lo   = {1'b0, c_full1[SW-1:0]};
        c2_abs  = c2_reg[CW-1] ? CW'(-c2_reg) : CW'(c2_reg);
        num_abs = num_reg[tpi_pkg::NUM_W-1] ? tpi_pkg::NUM_W'(-num_reg)
                                            : tpi_pkg::NUM_W'(num_reg);
    end

    // Quotient at least 2^QUOT_W saturates anyway: clamp it there
    always_comb
    begin
        qmag     = div_tag.ovf ? (tpi_pkg::QMAG_W'(1) << tpi_pkg::QUOT_W)
                               : {1'b0, div_quot};
        qsgn     = div_tag.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        res_wide = tpi_pkg::RES_W'(div_tag.first_value) - tpi_pkg::RES_W'(qsgn);
        res_top  = res_wide[tpi_pkg::RES_W-1:VW-1];
        result_next.degenerate = div_tag.degen;
        if (div_tag.degen)
        begin
            result_next.interpolated_value = '0;
        end
        else if (res_top == '0 || res_top == '1)
        begin
            result_next.interpolated_value = res_wide[VW-1:0];
        end
        else if (res_wide[tpi_pkg::RES_W-1])
        begin
            result_next.interpolated_value = tpi_pkg::VALUE_MIN;
        end
        else
        begin
            result_next.interpolated_value = tpi_pkg::VALUE_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            s6_valid_reg     <= 1'b0;
            s7_valid_reg     <= 1'b0;
            s8_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg     <= query_valid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            s5_valid_reg     <= s4_valid_reg;
            s6_valid_reg     <= s5_valid_reg;
            s7_valid_reg     <= s6_valid_reg;
            s8_valid_reg     <= s7_valid_reg;
            result_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlon2_reg   <= DW'(query.second_lon)   - DW'(query.first_lon);
            dlat2_reg   <= DW'(query.second_lat)   - DW'(query.first_lat);
            dval2_reg   <= DW'(query.second_value) - DW'(query.first_value);
            dlon3_reg   <= DW'(query.third_lon)    - DW'(query.first_lon);
            dlat3_reg   <= DW'(query.third_lat)    - DW'(query.first_lat);
            dval3_reg   <= DW'(query.third_value)  - DW'(query.first_value);
            dlonq1_reg  <= DW'(query.query_lon)    - DW'(query.first_lon);
            dlatq1_reg  <= DW'(query.query_lat)    - DW'(query.first_lat);
            val1_s1_reg <= query.first_value;

            pa_reg      <= PW'(dlat2_reg) * PW'(dval3_reg);
            pb_reg      <= PW'(dlat3_reg) * PW'(dval2_reg);
            pc_reg      <= PW'(dval2_reg) * PW'(dlon3_reg);
            pd_reg      <= PW'(dval3_reg) * PW'(dlon2_reg);
            pe_reg      <= PW'(dlon2_reg) * PW'(dlat3_reg);
            pf_reg      <= PW'(dlon3_reg) * PW'(dlat2_reg);
            dlonq2_reg  <= dlonq1_reg;
            dlatq2_reg  <= dlatq1_reg;
            val1_s2_reg <= val1_s1_reg;

            c0_reg      <= pa_reg - pb_reg;
            c1_reg      <= pc_reg - pd_reg;
            c2_reg      <= pe_reg - pf_reg;
            dlonq3_reg  <= dlonq2_reg;
            dlatq3_reg  <= dlatq2_reg;
            val1_s3_reg <= val1_s2_reg;

            h0_reg       <= tpi_pkg::PH_W'(c0_hi) * tpi_pkg::PH_W'(dlonq3_reg);
            h1_reg       <= tpi_pkg::PH_W'(c1_hi) * tpi_pkg::PH_W'(dlatq3_reg);
            l0_reg       <= tpi_pkg::PL_W'(c0_lo) * tpi_pkg::PL_W'(dlonq3_reg);
            l1_reg       <= tpi_pkg::PL_W'(c1_lo) * tpi_pkg::PL_W'(dlatq3_reg);
            dmag_s4_reg  <= c2_abs[tpi_pkg::DMAG_W-1:0];
            dneg_s4_reg  <= c2_reg[CW-1];
            degen_s4_reg <= (c2_reg == '0);
            val1_s4_reg  <= val1_s3_reg;

            sh_reg       <= tpi_pkg::SH_W'(h0_reg) + tpi_pkg::SH_W'(h1_reg);
            sl_reg       <= tpi_pkg::SL_W'(l0_reg) + tpi_pkg::SL_W'(l1_reg);
            dmag_s5_reg  <= dmag_s4_reg;
            dneg_s5_reg  <= dneg_s4_reg;
            degen_s5_reg <= degen_s4_reg;
            val1_s5_reg  <= val1_s4_reg;

            // The true numerator fits NUM_W bits, so wrapping here is exact
            num_reg      <= tpi_pkg::NUM_W'({sh_reg, {SW{1'b0}}}) + tpi_pkg::NUM_W'(sl_reg);
            dmag_s6_reg  <= dmag_s5_reg;
            dneg_s6_reg  <= dneg_s5_reg;
            degen_s6_reg <= degen_s5_reg;
            val1_s6_reg  <= val1_s5_reg;

            nmag_reg     <= num_abs[tpi_pkg::NMAG_W-1:0];
            dmag_s7_reg  <= dmag_s6_reg;
            qneg_s7_reg  <= num_reg[tpi_pkg::NUM_W-1] ^ dneg_s6_reg;
            degen_s7_reg <= degen_s6_reg;
            val1_s7_reg  <= val1_s6_reg;

            drem_reg              <= nmag_reg[tpi_pkg::NMAG_W-1:tpi_pkg::QUOT_W];
            dlow_reg              <= nmag_reg[tpi_pkg::QUOT_W-1:0];
            ddvs_reg              <= dmag_s7_reg;
            dtag_reg.first_value  <= val1_s7_reg;
            dtag_reg.neg          <= qneg_s7_reg;
            dtag_reg.ovf          <= (nmag_reg[tpi_pkg::NMAG_W-1:tpi_pkg::QUOT_W] >= dmag_s7_reg);
            dtag_reg.degen        <= degen_s7_reg;

            result_reg <= result_next;
        end
    end

    tpi_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .src_valid  (s8_valid_reg),
        .src_rem    (drem_reg),
        .src_low    (dlow_reg),
        .src_dvs    (ddvs_reg),
        .src_tag    (dtag_reg),
        .done_valid (div_valid),
        .done_quot  (div_quot),
        .done_rem   (div_rem),
        .done_dvs   (div_dvs),
        .done_tag   (div_tag)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A collinear triangle always reports a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |-> result.interpolated_value == '0)
    else $error("degenerate result with nonzero value");

    // An accepted transaction occupies the first stage on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        query_valid && query_ready |=> s1_valid_reg)
    else $error("accepted transaction missing from first stage");

    // Without overflow or a degenerate divisor the divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        div_valid && !div_tag.ovf && !div_tag.degen |-> div_rem < div_dvs)
    else $error("divider remainder not below divisor");

endmodule
